/* design/finite_queue_occupancy_monitor_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the queue occupancy monitor
// Concurrent checks sampled on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FINITE_QUEUE_OCCUPANCY_MONITOR_MACROS_SVH
`define FINITE_QUEUE_OCCUPANCY_MONITOR_MACROS_SVH

// same-cycle implication
`define FQOM_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("queue monitor check failed");

// next-cycle implication
`define FQOM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("queue monitor check failed");

`endif

/* design/fqom_pkg.sv */
// ----------------------------------------------------------------------------
// fqom_pkg
// Item types, opcodes, statistic selectors and register indexes.
// ----------------------------------------------------------------------------
package fqom_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVAL = 2'd0,
        OP_TX_END  = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [3:0] SEL_HIST      = 4'd0;
    localparam logic [3:0] SEL_GENERATED = 4'd1;
    localparam logic [3:0] SEL_SENT      = 4'd2;
    localparam logic [3:0] SEL_DROPPED   = 4'd3;
    localparam logic [3:0] SEL_PEAK      = 4'd4;
    localparam logic [3:0] SEL_LEVEL_SUM = 4'd5;
    localparam logic [3:0] SEL_SAMPLES   = 4'd6;
    localparam logic [3:0] SEL_IDLE_TIME = 4'd7;
    localparam logic [3:0] SEL_IDLE_CNT  = 4'd8;

    localparam logic [3:0] CFG_QUEUE_LIMIT = 4'd0;
    localparam logic [3:0] CFG_TX_DURATION = 4'd1;

    localparam logic [7:0]  QUEUE_LIMIT_RST = 8'd6;
    localparam logic [15:0] TX_DURATION_RST = 16'd5;

    // output queue: three entries cover the stage-1 register at full rate
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] time_tick;
        logic [3:0]  stat_select;
        logic [5:0]  bin_index;
    } in_t;

    typedef struct packed {
        logic [7:0]  queue_level;
        logic        channel_busy;
        logic        schedule_tx_end;
        logic [31:0] tx_end_time;
        logic        dropped;
        logic        underflow_error;
        logic [47:0] read_data;
    } out_t;

endpackage

/* design/finite_queue_occupancy_monitor.sv */
// ----------------------------------------------------------------------------
// finite_queue_occupancy_monitor
// Occupancy, drop and idle statistics for a single-server finite queue.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Carries
//   -------   ----------------------------   -----------------------------------
//   events    s_valid / s_ready / s_data     arrival, transmit end or stat read
//   results   m_valid / m_ready / m_data     one result item per event item
//   config    cfg_valid / cfg_ready /        queue_limit (0), tx_duration (1)
//             cfg_index / cfg_data
//
// One event item is taken per cycle while s_ready is high. The histogram RAM
// read is registered with the item; in stage 1 the bin is incremented and
// written back. A three-entry result queue keeps the event side running while
// the result side stalls; s_ready drops when that queue could overflow and
// during the clearing sweep: after reset the histogram RAM is swept to zero,
// one bin per cycle, and no event item is taken until the last bin is clear.
// Configuration writes are taken at any time.
//
// The scalar statistics live in registers and are updated as an item is
// taken. The histogram lives in a RAM; a write-back that meets a read of the
// same bin in the next item is forwarded.
// ----------------------------------------------------------------------------
module finite_queue_occupancy_monitor #(
    parameter int HIST_BINS   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            s_valid,
    output logic            s_ready,
    input  fqom_pkg::in_t   s_data,

    output logic            m_valid,
    input  logic            m_ready,
    output fqom_pkg::out_t  m_data,

    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [3:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import fqom_pkg::*;

    localparam int BIN_W = $clog2(HIST_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);

    // configuration
    logic [7:0]  queue_limit_reg;
    logic [15:0] tx_duration_reg;

    // scalar statistics
    logic [7:0]             occ_reg, occ_next;
    logic                   busy_reg, busy_next;
    logic [31:0]            idle_start_reg, idle_start_next;
    logic [COUNT_WIDTH-1:0] gen_reg, gen_next;
    logic [COUNT_WIDTH-1:0] sent_reg, sent_next;
    logic [COUNT_WIDTH-1:0] drop_reg, drop_next;
    logic [7:0]             peak_reg, peak_next;
    logic [47:0]            lsum_reg, lsum_next;
    logic [COUNT_WIDTH-1:0] samples_reg, samples_next;
    logic [47:0]            idle_sum_reg, idle_sum_next;
    logic [COUNT_WIDTH-1:0] idle_cnt_reg, idle_cnt_next;

    // histogram clearing sweep
    logic             clearing_reg;
    logic [BIN_W-1:0] clr_addr_reg;

    // stage 1: RAM data returns
    logic             s1_valid_reg;
    logic             s1_inc_reg, s1_inc_next;
    logic             s1_hrd_reg, s1_hrd_next;
    logic [BIN_W-1:0] s1_addr_reg;
    logic             s1_fwd_reg, s1_fwd_next;
    logic [COUNT_WIDTH-1:0] s1_fwd_data_reg;
    out_t             s1_res_reg, s1_res_next;

    // RAM ports
    logic                   ram_we;
    logic [BIN_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [BIN_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] ram_q;

    logic                   accept;
    logic [COUNT_WIDTH-1:0] bin_eff;
    logic [COUNT_WIDTH-1:0] bin_inc;
    out_t                   s1_out;
    logic [OUT_CNT_W-1:0]   fifo_count;

    // stage 0 working values
    logic [8:0]  occ_inc;
    logic [7:0]  occ_dec;
    logic [7:0]  cap;
    logic [31:0] idle_gap;
    logic        sample;
    logic [8:0]  level;
    logic [15:0] level_wide;
    logic [15:0] bin_wide;
    logic        bin_in_range;

    assign cfg_ready = 1'b1;

    // hold off new items while clearing or when the result queue could fill
    assign s_ready = !clearing_reg &&
                     ((3'(fifo_count) + 3'(s1_valid_reg)) < 3'(OUT_DEPTH));
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // stage 0: event decode and scalar update
    // ------------------------------------------------------------------
    always_comb begin
        occ_next        = occ_reg;
        busy_next       = busy_reg;
        idle_start_next = idle_start_reg;
        gen_next        = gen_reg;
        sent_next       = sent_reg;
        drop_next       = drop_reg;
        peak_next       = peak_reg;
        lsum_next       = lsum_reg;
        samples_next    = samples_reg;
        idle_sum_next   = idle_sum_reg;
        idle_cnt_next   = idle_cnt_reg;
        s1_res_next     = '0;
        s1_hrd_next     = 1'b0;
        sample          = 1'b0;
        level           = '0;

        occ_inc      = {1'b0, occ_reg} + 9'd1;
        occ_dec      = occ_reg - 8'd1;
        cap          = (queue_limit_reg == 8'hFF) ? 8'hFF : queue_limit_reg + 8'd1;
        idle_gap     = s_data.time_tick - idle_start_reg;
        bin_wide     = {10'd0, s_data.bin_index};
        bin_in_range = (32'(s_data.bin_index) < 32'(HIST_BINS));

        case (s_data.opcode)
            OP_ARRIVAL: begin
                gen_next = gen_reg + 1'b1;
                if (!busy_reg) begin
                    // channel idle: close the idle period, start sending
                    busy_next                   = 1'b1;
                    s1_res_next.schedule_tx_end = 1'b1;
                    s1_res_next.tx_end_time     = s_data.time_tick + 32'(tx_duration_reg);
                    idle_sum_next               = idle_sum_reg + 48'(idle_gap);
                    idle_cnt_next               = idle_cnt_reg + 1'b1;
                    sample                      = 1'b1;
                    level                       = occ_inc;
                end
                if (occ_inc > {1'b0, cap}) begin
                    occ_next            = cap;
                    drop_next           = drop_reg + 1'b1;
                    s1_res_next.dropped = 1'b1;
                end else begin
                    occ_next = occ_inc[7:0];
                end
                if (occ_next > peak_reg) begin
                    peak_next = occ_next;
                end
            end
            OP_TX_END: begin
                if (occ_reg == 8'd0) begin
                    s1_res_next.underflow_error = 1'b1;
                end else begin
                    sent_next = sent_reg + 1'b1;
                    occ_next  = occ_dec;
                    sample    = 1'b1;
                    level     = {1'b0, occ_dec};
                    if (occ_dec == 8'd0) begin
                        busy_next       = 1'b0;
                        idle_start_next = s_data.time_tick;
                    end else begin
                        s1_res_next.schedule_tx_end = 1'b1;
                        s1_res_next.tx_end_time     =
                            s_data.time_tick + 32'(tx_duration_reg);
                    end
                end
            end
            OP_READ: begin
                unique case (s_data.stat_select)
                    SEL_HIST:      s1_hrd_next = bin_in_range;
                    SEL_GENERATED: s1_res_next.read_data = 48'(gen_reg);
                    SEL_SENT:      s1_res_next.read_data = 48'(sent_reg);
                    SEL_DROPPED:   s1_res_next.read_data = 48'(drop_reg);
                    SEL_PEAK:      s1_res_next.read_data = 48'(peak_reg);
                    SEL_LEVEL_SUM: s1_res_next.read_data = lsum_reg;
                    SEL_SAMPLES:   s1_res_next.read_data = 48'(samples_reg);
                    SEL_IDLE_TIME: s1_res_next.read_data = idle_sum_reg;
                    SEL_IDLE_CNT:  s1_res_next.read_data = 48'(idle_cnt_reg);
                    default:       s1_res_next.read_data = '0;
                endcase
            end
            default: begin
                // unused opcode: report the level, change nothing
            end
        endcase

        if (sample) begin
            lsum_next    = lsum_reg + 48'(level);
            samples_next = samples_reg + 1'b1;
        end

        // clamp the sampled level into the last bin
        level_wide = 16'(level);
        if (32'(level) < 32'(HIST_BINS - 1)) begin
            rd_addr = level_wide[BIN_W-1:0];
        end else begin
            rd_addr = LAST_BIN;
        end
        if (!sample) begin
            rd_addr = bin_wide[BIN_W-1:0];
        end

        s1_inc_next                = sample;
        s1_res_next.queue_level    = occ_next;
        s1_res_next.channel_busy   = busy_next;
    end

    // ------------------------------------------------------------------
    // stage 1: increment and write back, forward a same-bin write
    // ------------------------------------------------------------------
    assign bin_eff = s1_fwd_reg ? s1_fwd_data_reg : ram_q;
    assign bin_inc = bin_eff + 1'b1;

    assign s1_fwd_next = s1_valid_reg && s1_inc_reg && (s1_addr_reg == rd_addr);

    always_comb begin
        s1_out = s1_res_reg;
        if (s1_hrd_reg) begin
            s1_out.read_data = 48'(bin_eff);
        end
    end

    always_comb begin
        if (clearing_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_valid_reg && s1_inc_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = bin_inc;
        end
    end

    fqom_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    fqom_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (s1_out),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        // stage 1 payload
        if (accept) begin
            s1_inc_reg      <= s1_inc_next;
            s1_hrd_reg      <= s1_hrd_next;
            s1_addr_reg     <= rd_addr;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_data_reg <= bin_inc;
            s1_res_reg      <= s1_res_next;
        end

        if (!aresetn) begin
            queue_limit_reg <= QUEUE_LIMIT_RST;
            tx_duration_reg <= TX_DURATION_RST;
            occ_reg         <= '0;
            busy_reg        <= 1'b0;
            idle_start_reg  <= '0;
            gen_reg         <= '0;
            sent_reg        <= '0;
            drop_reg        <= '0;
            peak_reg        <= '0;
            lsum_reg        <= '0;
            samples_reg     <= '0;
            idle_sum_reg    <= '0;
            idle_cnt_reg    <= '0;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[7:0];
                    CFG_TX_DURATION: tx_duration_reg <= cfg_data;
                    default: begin
                        // drop writes to unknown registers
                    end
                endcase
            end

            // advance the clearing sweep
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_BIN) begin
                    clearing_reg <= 1'b0;
                end
            end

            s1_valid_reg <= accept;

            if (accept) begin
                occ_reg        <= occ_next;
                busy_reg       <= busy_next;
                idle_start_reg <= idle_start_next;
                gen_reg        <= gen_next;
                sent_reg       <= sent_next;
                drop_reg       <= drop_next;
                peak_reg       <= peak_next;
                lsum_reg       <= lsum_next;
                samples_reg    <= samples_next;
                idle_sum_reg   <= idle_sum_next;
                idle_cnt_reg   <= idle_cnt_next;
            end
        end
    end

endmodule

/* design/fqom_ram.sv */
// ----------------------------------------------------------------------------
// fqom_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fqom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/fqom_out_fifo.sv */
// ----------------------------------------------------------------------------
// fqom_out_fifo
// Small result queue decoupling the pipeline from the result channel.
// ----------------------------------------------------------------------------
module fqom_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  fqom_pkg::out_t            push_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fqom_pkg::out_t            m_data,
    output logic [fqom_pkg::OUT_CNT_W-1:0] count
);
    import fqom_pkg::*;

    out_t                 entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic                 pop;

    function automatic logic [OUT_PTR_W-1:0] ptr_inc(input logic [OUT_PTR_W-1:0] p);
        ptr_inc = (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/fqom_checker.sv */
// ----------------------------------------------------------------------------
// fqom_checker
// Port-level checks on the result channel of the queue monitor.
// ----------------------------------------------------------------------------
`include "finite_queue_occupancy_monitor_macros.svh"

module fqom_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input fqom_pkg::out_t m_data
);
    import fqom_pkg::*;

    logic end_time_ok;
    logic underflow_quiet;

    assign end_time_ok     = m_data.schedule_tx_end || (m_data.tx_end_time == 32'd0);
    assign underflow_quiet = (m_data.queue_level == 8'd0) && !m_data.channel_busy &&
                             !m_data.schedule_tx_end && !m_data.dropped;

    // a stalled result holds
    `FQOM_CHECK_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // end time only accompanies a scheduled transmission
    `FQOM_CHECK_IMP(a_end_time_zero, m_valid, end_time_ok)

    // an underflow leaves an empty, idle queue and raises nothing else
    `FQOM_CHECK_IMP(a_underflow_idle, m_valid && m_data.underflow_error, underflow_quiet)

    // idle channel means an empty queue
    `FQOM_CHECK_IMP(a_idle_empty, m_valid && !m_data.channel_busy, m_data.queue_level == 8'd0)

endmodule

bind finite_queue_occupancy_monitor fqom_checker u_fqom_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue occupancy monitor testbench
// Drives arrival, transmit-end and statistic-read events through a directed
// table and then through simulated queue traffic. Directed rows may fix their
// report; a queue model predicts the rest. Each is compared with the output.
// ----------------------------------------------------------------------------
module testbench;
    import fqom_pkg::*;

    localparam int         NBINS     = 64;
    localparam logic [3:0] CFG_SPARE = 4'hF;   // index that maps to no register

    typedef struct {
        in_t  ev;
        bit   typed;
        out_t want;
    } step_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Model of the queue: registers, occupancy and statistics
    logic [7:0]  lim_r;
    logic [15:0] dur_r;
    logic [7:0]  occ;
    logic        busy;
    logic [31:0] idle_from;
    logic [31:0] hist [NBINS];
    logic [31:0] gen_cnt, sent_cnt, drop_cnt, sample_cnt, idle_cnt;
    logic [7:0]  peak;
    logic [47:0] level_sum, idle_sum;

    // Event timeline of the simulated traffic
    logic [31:0] arr_at;
    logic [31:0] end_due;
    bit          end_pending;

    out_t        expected_reports [$];
    step_row_t   plan [$];
    int          idle_pct = 18;
    int          errors = 0;
    int          items_driven = 0;
    int          reports_checked = 0;
    int          drops_seen = 0;
    int          underflows_seen = 0;
    int          peak_seen = 0;
    int          settings_used = 1;

    finite_queue_occupancy_monitor #(
        .HIST_BINS   (NBINS),
        .COUNT_WIDTH (32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("timed out with %0d reports outstanding", expected_reports.size());
        $display("Mismatches found");
        $finish;
    end

    // Histogram update, level sum and sample count for one sampled level
    function automatic void record_level(input logic [8:0] lvl);
        int bin;
        bin = (lvl < NBINS - 1) ? int'(lvl) : NBINS - 1;
        hist[bin]  = hist[bin] + 32'd1;
        level_sum  = level_sum + 48'(lvl);
        sample_cnt = sample_cnt + 32'd1;
    endfunction

    // Apply one event to the queue model and return the report it causes
    function automatic out_t predict_report(input in_t ev);
        out_t        r;
        logic [8:0]  cap;
        logic [31:0] gap;
        r = '0;
        case (ev.opcode)
            OP_ARRIVAL: begin
                cap = {1'b0, lim_r} + 9'd1;
                if (cap > 9'd255) begin
                    cap = 9'd255;
                end
                gen_cnt = gen_cnt + 32'd1;
                // idle channel: close the idle period and start sending
                if (!busy) begin
                    busy              = 1'b1;
                    r.schedule_tx_end = 1'b1;
                    r.tx_end_time     = ev.time_tick + {16'd0, dur_r};
                    gap               = ev.time_tick - idle_from;
                    idle_sum          = idle_sum + {16'd0, gap};
                    idle_cnt          = idle_cnt + 32'd1;
                    record_level({1'b0, occ} + 9'd1);
                end
                // full queue: hold at the cap and drop the packet
                if ({1'b0, occ} + 9'd1 > cap) begin
                    occ       = cap[7:0];
                    drop_cnt  = drop_cnt + 32'd1;
                    r.dropped = 1'b1;
                end else begin
                    occ = occ + 8'd1;
                end
                if (occ > peak) begin
                    peak = occ;
                end
            end
            OP_TX_END: begin
                if (occ == 8'd0) begin
                    r.underflow_error = 1'b1;
                end else begin
                    sent_cnt = sent_cnt + 32'd1;
                    occ      = occ - 8'd1;
                    record_level({1'b0, occ});
                    if (occ == 8'd0) begin
                        busy      = 1'b0;
                        idle_from = ev.time_tick;
                    end else begin
                        r.schedule_tx_end = 1'b1;
                        r.tx_end_time     = ev.time_tick + {16'd0, dur_r};
                    end
                end
            end
            OP_READ: begin
                case (ev.stat_select)
                    SEL_HIST:      r.read_data = {16'd0, hist[ev.bin_index]};
                    SEL_GENERATED: r.read_data = {16'd0, gen_cnt};
                    SEL_SENT:      r.read_data = {16'd0, sent_cnt};
                    SEL_DROPPED:   r.read_data = {16'd0, drop_cnt};
                    SEL_PEAK:      r.read_data = {40'd0, peak};
                    SEL_LEVEL_SUM: r.read_data = level_sum;
                    SEL_SAMPLES:   r.read_data = {16'd0, sample_cnt};
                    SEL_IDLE_TIME: r.read_data = idle_sum;
                    SEL_IDLE_CNT:  r.read_data = {16'd0, idle_cnt};
                    default:       r.read_data = '0;
                endcase
            end
            default: ;
        endcase
        r.queue_level  = occ;
        r.channel_busy = busy;
        return r;
    endfunction

    function automatic string show(input out_t r);
        return $sformatf("level=%0d busy=%0b sched=%0b end=%h drop=%0b under=%0b data=%h",
                         r.queue_level, r.channel_busy, r.schedule_tx_end, r.tx_end_time,
                         r.dropped, r.underflow_error, r.read_data);
    endfunction

    task automatic add_row(input opcode_t op, input logic [31:0] t, input logic [3:0] sel,
                           input logic [5:0] bin, input bit typed, input out_t want);
        step_row_t row;
        row.ev.opcode      = op;
        row.ev.time_tick   = t;
        row.ev.stat_select = sel;
        row.ev.bin_index   = bin;
        row.typed          = typed;
        row.want           = want;
        plan.push_back(row);
    endtask

    // Predict, then offer one item; the report is expected once the item is taken.
    // Entered and left at a falling edge.
    task automatic drive_item(input in_t ev, input bit typed, input out_t want);
        out_t p;
        p = predict_report(ev);
        // follow the transmit-end schedule for the traffic generator
        if (p.schedule_tx_end) begin
            end_pending = 1'b1;
            end_due     = p.tx_end_time;
        end else if (!p.channel_busy) begin
            end_pending = 1'b0;
        end
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        expected_reports.push_back(typed ? want : p);
        items_driven++;
        @(negedge aclk);
    endtask

    // Drain the block, then write the registers; the spare index must be ignored
    task automatic configure(input logic [7:0] lim, input logic [15:0] dur, input bit poke);
        logic [3:0]  idx [3];
        logic [15:0] val [3];
        int          n;
        idx[0] = CFG_QUEUE_LIMIT; val[0] = {8'd0, lim};
        idx[1] = CFG_TX_DURATION; val[1] = dur;
        idx[2] = CFG_SPARE;       val[2] = 16'hFFFF;
        n      = poke ? 3 : 2;
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                CFG_QUEUE_LIMIT: lim_r = val[i][7:0];
                CFG_TX_DURATION: dur_r = val[i];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Simulated queue traffic: mostly arrivals and transmit ends in time order,
    // with reads mixed in and some noise (any opcode at any time).
    task automatic run_traffic(input int n, input int gap_max);
        in_t               ev;
        int                roll;
        logic signed [31:0] lead;
        repeat (n) begin
            roll           = $urandom_range(99);
            ev             = '0;
            ev.stat_select = 4'($urandom_range(15));
            ev.bin_index   = 6'($urandom_range(63));
            lead           = $signed(end_due - arr_at);
            if (roll < 12) begin
                ev.opcode    = OP_READ;
                ev.time_tick = arr_at;
            end else if (roll < 16) begin
                ev.opcode    = 2'($urandom_range(3));
                ev.time_tick = $urandom;
            end else if (end_pending && lead <= 0) begin
                ev.opcode    = OP_TX_END;
                ev.time_tick = end_due;
            end else begin
                ev.opcode    = OP_ARRIVAL;
                ev.time_tick = arr_at;
                arr_at       = arr_at + 32'($urandom_range(gap_max));
            end
            drive_item(ev, 1'b0, '0);
        end
    endtask

    // Report checker: compare every taken report with the oldest expectation
    initial begin
        out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected report: %s", show(m_data));
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (m_data !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("report %0d differs", reports_checked);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(m_data));
                        end
                    end
                    reports_checked++;
                    if (m_data.dropped) drops_seen++;
                    if (m_data.underflow_error) underflows_seen++;
                    if (int'(m_data.queue_level) > peak_seen) begin
                        peak_seen = int'(m_data.queue_level);
                    end
                end
            end
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        // model state after reset
        lim_r = QUEUE_LIMIT_RST;  dur_r = TX_DURATION_RST;
        occ = '0;  busy = 1'b0;  idle_from = '0;  peak = '0;
        gen_cnt = '0;  sent_cnt = '0;  drop_cnt = '0;  sample_cnt = '0;  idle_cnt = '0;
        level_sum = '0;  idle_sum = '0;
        foreach (hist[i]) hist[i] = '0;
        arr_at = '0;  end_due = '0;  end_pending = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset settings: limit 6, duration 5.
        // Reads on a fresh block, a transmit end on an empty queue, the unused opcode
        add_row(OP_READ,   32'd0, SEL_GENERATED, 6'd0, 1'b1, '0);
        add_row(OP_TX_END, 32'd0, SEL_HIST,      6'd0, 1'b1,
                out_t'{8'd0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1, 48'd0});
        add_row(OP_NONE,   32'd0, 4'hF,          6'd63, 1'b1, '0);
        add_row(OP_READ,   32'd0, 4'hF,          6'd63, 1'b1, '0);
        add_row(OP_READ,   32'd0, SEL_HIST,      6'd63, 1'b1, '0);
        // first arrival at the last tick: the end time wraps past zero
        add_row(OP_ARRIVAL, 32'hFFFF_FFFF, SEL_HIST, 6'd0, 1'b1,
                out_t'{8'd1, 1'b1, 1'b1, 32'd4, 1'b0, 1'b0, 48'd0});
        repeat (6) add_row(OP_ARRIVAL, 32'hFFFF_FFFF, SEL_HIST, 6'd0, 1'b0, '0);
        // queue full at limit plus one: drop
        add_row(OP_ARRIVAL, 32'hFFFF_FFFF, SEL_HIST, 6'd0, 1'b1,
                out_t'{8'd7, 1'b1, 1'b0, 32'd0, 1'b1, 1'b0, 48'd0});
        add_row(OP_TX_END, 32'd4, SEL_HIST, 6'd0, 1'b0, '0);
        // time going backwards
        add_row(OP_TX_END, 32'd2, SEL_HIST, 6'd0, 1'b0, '0);
        for (int s = 0; s <= 8; s++) begin
            add_row(OP_READ, 32'd2, 4'(s), 6'(s), 1'b0, '0);
        end
        // selector past the last statistic
        add_row(OP_READ, 32'd2, 4'd9, 6'd0, 1'b1,
                out_t'{8'd5, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 48'd0});
        foreach (plan[i]) begin
            drive_item(plan[i].ev, plan[i].typed, plan[i].want);
        end
        arr_at = 32'd10;

        // No waiting room at all, one-tick transmissions
        configure(8'd0, 16'd1, 1'b0);
        run_traffic(90, 3);
        // Widest queue, longest transmissions: climb to the level cap and
        // into the histogram's last bin, with the clock wrapping on the way
        configure(8'd254, 16'd65535, 1'b0);
        arr_at = 32'hFFFE_0000;
        run_traffic(320, 1024);
        // Small queue near balance, no idling on either side
        configure(8'd3, 16'd7, 1'b1);
        idle_pct = 0;
        run_traffic(120, 14);
        // Cap sits exactly on the last histogram bin
        configure(8'd62, 16'd40, 1'b0);
        idle_pct = 18;
        run_traffic(170, 45);

        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d event items over %0d register settings, %0d reports checked",
                 items_driven, settings_used, reports_checked);
        $display("peak level %0d, %0d drops, %0d empty-queue transmit ends",
                 peak_seen, drops_seen, underflows_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
